// ===== src/msh_lap_pkg.sv =====
// Shared types and constants for the umbrella-operator mesh Laplacian block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package msh_lap_pkg;

  // Index widths are fixed by the item fields; depths follow from them.
  localparam int VTX_W      = 10;
  localparam int SLOT_W     = 4;
  localparam int VERTS      = 1 << VTX_W;
  localparam int NEIGH_MAX  = 1 << SLOT_W;
  localparam int NBR_ADDR_W = VTX_W + SLOT_W;
  localparam int ENTRY_W    = VTX_W + 1;

  // Coordinates: three lanes are stored; lanes at or beyond DIMS report zero.
  localparam int DIMS  = 3;
  localparam int LANES = 3;
  localparam int POS_W = 24;
  localparam int VEC_W = POS_W + 1;
  localparam int CNT_W = SLOT_W + 1;
  // A sum of up to NEIGH_MAX differences, each of magnitude below 2**POS_W.
  localparam int MAG_W = POS_W + SLOT_W;
  localparam int SUM_W = MAG_W + 1;

  localparam int CFG_W       = 5;
  localparam int LIMIT_RESET = 16;

  // Divider retires RADIX quotient bits per cycle; MAG_W is a multiple of it.
  localparam int RADIX     = 2;
  localparam int DIV_STEPS = MAG_W / RADIX;

  typedef enum logic [1:0] {
    OP_LOAD_POS = 2'd0,
    OP_LOAD_NBR = 2'd1,
    OP_COMPUTE  = 2'd2
  } op_t;

  typedef struct packed {
    logic                        en;
    logic [VTX_W-1:0]            addr;
    logic [LANES-1:0][POS_W-1:0] data;
  } pos_wr_t;

  typedef struct packed {
    logic                  en;
    logic [NBR_ADDR_W-1:0] addr;
    logic [ENTRY_W-1:0]    data;
  } nbr_wr_t;

  typedef struct packed {
    logic                        start;
    logic [CNT_W-1:0]            count;
    logic [LANES-1:0][SUM_W-1:0] sum;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic [LANES-1:0][VEC_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/msh_lap_store.sv =====
// Position memory (x, y, z per vertex) and neighbor slot table.
// Single write port and one registered read port each; uses msh_lap_pkg.
`default_nettype none

module msh_lap_store
  import msh_lap_pkg::*;
(
  input  wire logic                        clk,
  input  wire pos_wr_t                     pos_wr,
  input  wire logic [VTX_W-1:0]            pos_raddr,
  output logic      [LANES-1:0][POS_W-1:0] pos_rdata,
  input  wire nbr_wr_t                     nbr_wr,
  input  wire logic [NBR_ADDR_W-1:0]       nbr_raddr,
  output logic      [ENTRY_W-1:0]          nbr_rdata
);

  logic [LANES*POS_W-1:0] pos_mem [VERTS];
  logic [ENTRY_W-1:0]     nbr_mem [VERTS*NEIGH_MAX];

  always_ff @(posedge clk) begin
    if (pos_wr.en) begin
      pos_mem[pos_wr.addr] <= pos_wr.data;
    end
    pos_rdata <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (nbr_wr.en) begin
      nbr_mem[nbr_wr.addr] <= nbr_wr.data;
    end
    nbr_rdata <= nbr_mem[nbr_raddr];
  end

endmodule

`default_nettype wire

// ===== src/msh_lap_div.sv =====
// Signed sum-by-count divider, one lane per coordinate, shared divisor.
// Restoring division on magnitudes, RADIX bits per cycle; uses msh_lap_pkg.
`default_nettype none

module msh_lap_div
  import msh_lap_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic                        busy;
  logic                        done;
  logic [STEP_W-1:0]           step;
  logic                        last;
  logic [CNT_W-1:0]            dvsr;
  logic [LANES-1:0][MAG_W-1:0] mag;
  logic [LANES-1:0][MAG_W-1:0] mag_next;
  logic [LANES-1:0][MAG_W-1:0] mag_init;
  logic [LANES-1:0][CNT_W-1:0] rem;
  logic [LANES-1:0][CNT_W-1:0] rem_next;
  logic [LANES-1:0]            neg;
  logic [LANES-1:0][VEC_W-1:0] quo;

  assign last = (step == STEP_W'(DIV_STEPS - 1));

  always_comb begin
    logic [SUM_W-1:0] neg_sum;
    for (int l = 0; l < LANES; l++) begin
      neg_sum     = -req.sum[l];
      mag_init[l] = req.sum[l][SUM_W-1] ? neg_sum[MAG_W-1:0] : req.sum[l][MAG_W-1:0];
    end
  end

  // The remainder stays below the divisor, so it fits in CNT_W bits.
  always_comb begin
    logic [CNT_W-1:0] r;
    logic [CNT_W:0]   sh;
    logic [RADIX-1:0] q;
    for (int l = 0; l < LANES; l++) begin
      r = rem[l];
      q = '0;
      for (int i = 0; i < RADIX; i++) begin
        sh = {r, mag[l][MAG_W-1-i]};
        if (sh >= {1'b0, dvsr}) begin
          sh             = sh - {1'b0, dvsr};
          q[RADIX-1-i]   = 1'b1;
        end
        r = sh[CNT_W-1:0];
      end
      mag_next[l] = {mag[l][MAG_W-RADIX-1:0], q};
      rem_next[l] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvsr <= req.count;
      for (int l = 0; l < LANES; l++) begin
        mag[l] <= mag_init[l];
        rem[l] <= '0;
        neg[l] <= req.sum[l][SUM_W-1];
      end
    end else if (busy) begin
      for (int l = 0; l < LANES; l++) begin
        mag[l] <= mag_next[l];
        rem[l] <= rem_next[l];
        if (last) begin
          quo[l] <= neg[l] ? -mag_next[l][VEC_W-1:0] : mag_next[l][VEC_W-1:0];
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

`default_nettype wire

// ===== src/mesh_umbrella_laplacian_top.sv =====
// Top level of the umbrella-operator mesh Laplacian: item decode, slot scan
// sequencer, accumulation and output register. Uses msh_lap_pkg, msh_lap_store
// and msh_lap_div.
//
//   channel   direction  handshake              payload
//   s_axis    in         tvalid/tready          tuser opcode, tdata vertex..pos_z
//   m_axis    out        tvalid/tready          tuser skipped, tdata vec_x..count
//   cfg       in         cfg_we (no wait)       cfg_data = neighbors_in_use
//
// Load items write memory at the accepting edge.
// A compute item first fetches the vertex and slot 0, then scans the slots (slot
// read, then neighbor position read), then runs the divider (14 steps, then its
// done flag) and finally loads the output register; a skipped vertex bypasses the
// divider and goes straight from the scan to the output register.
// Reset is synchronous and holds the input not ready; memories need no clearing.
// Only one item is in work at a time. A stalled output holds its result while
// the next load items are still taken; a new result waits until it is accepted.
`default_nettype none

module mesh_umbrella_laplacian_top
  import msh_lap_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // Fields from bit 0: vertex, slot, neighbor, neighbor_present, pos_x, pos_y,
  // pos_z, then zero fill.
  input  wire logic [103:0] s_axis_tdata,
  // Fields from bit 0: opcode.
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // Fields from bit 0: vec_x, vec_y, vec_z, neighbor_count.
  output logic [79:0]       m_axis_tdata,
  // Fields from bit 0: skipped.
  output logic [0:0]        m_axis_tuser,
  input  wire logic         cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int IN_SLOT_LO = VTX_W;
  localparam int IN_NBR_LO  = IN_SLOT_LO + SLOT_W;
  localparam int IN_PRES    = IN_NBR_LO + VTX_W;
  localparam int IN_POS_LO  = IN_PRES + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DIVIDE,
    ST_RESULT
  } state_t;

  state_t                      state;
  logic [CFG_W-1:0]            nbr_limit;
  logic [VTX_W-1:0]            vtx;
  logic [CNT_W-1:0]            limit;
  logic [CNT_W-1:0]            limit_in;
  logic [CNT_W-1:0]            issue_k;
  logic [CNT_W-1:0]            count;
  logic                        e_valid;
  logic                        p_valid;
  logic                        stopped;
  logic                        vpos_live;
  logic [LANES-1:0][POS_W-1:0] vpos;
  logic [LANES-1:0][SUM_W-1:0] acc;
  logic [LANES-1:0][SUM_W-1:0] acc_next;

  logic                        in_fire;
  op_t                         op;
  pos_wr_t                     pos_wr;
  nbr_wr_t                     nbr_wr;
  logic [VTX_W-1:0]            pos_raddr;
  logic [NBR_ADDR_W-1:0]       nbr_raddr;
  logic [LANES-1:0][POS_W-1:0] pos_rdata;
  logic [ENTRY_W-1:0]          nbr_rdata;
  logic                        ent_present;
  logic                        take_entry;
  logic                        stop_now;
  logic                        issue;
  logic                        scan_done;
  logic                        out_free;
  div_req_t                    div_req;
  div_rsp_t                    div_rsp;
  logic [LANES-1:0][VEC_W-1:0] vec;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = op_t'(s_axis_tuser);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Slot count of zero scans one slot; larger values saturate at the table width.
  always_comb begin
    if (nbr_limit == '0) begin
      limit_in = CNT_W'(1);
    end else if (nbr_limit > CFG_W'(NEIGH_MAX)) begin
      limit_in = CNT_W'(NEIGH_MAX);
    end else begin
      limit_in = CNT_W'(nbr_limit);
    end
  end

  assign pos_wr.en   = in_fire && (op == OP_LOAD_POS);
  assign pos_wr.addr = s_axis_tdata[VTX_W-1:0];
  assign pos_wr.data = s_axis_tdata[IN_POS_LO +: LANES*POS_W];
  assign nbr_wr.en   = in_fire && (op == OP_LOAD_NBR);
  assign nbr_wr.addr = {s_axis_tdata[VTX_W-1:0], s_axis_tdata[IN_SLOT_LO +: SLOT_W]};
  assign nbr_wr.data = {s_axis_tdata[IN_PRES], s_axis_tdata[IN_NBR_LO +: VTX_W]};

  // Scan pipeline: slot read, then the neighbor's position, then accumulate.
  // Once an end marker comes back, any slot already in flight is dropped.
  assign ent_present = nbr_rdata[ENTRY_W-1];
  assign take_entry  = (state == ST_SCAN) && e_valid && ent_present && !stopped;
  assign stop_now    = stopped || (e_valid && !ent_present);
  assign issue       = (state == ST_SCAN) && !stop_now && (issue_k < limit);
  assign scan_done   = (state == ST_SCAN) && !issue && !take_entry;

  assign pos_raddr = (state == ST_FETCH) ? vtx : nbr_rdata[VTX_W-1:0];
  assign nbr_raddr = {vtx, issue_k[SLOT_W-1:0]};

  always_comb begin
    logic [POS_W:0] diff;
    for (int d = 0; d < LANES; d++) begin
      diff = {pos_rdata[d][POS_W-1], pos_rdata[d]} - {vpos[d][POS_W-1], vpos[d]};
      acc_next[d] = acc[d];
      if (p_valid) begin
        acc_next[d] = acc[d] + {{(SUM_W-POS_W-1){diff[POS_W]}}, diff};
      end
    end
  end

  assign div_req.start = scan_done && (count != '0);
  assign div_req.count = count;
  assign div_req.sum   = acc_next;

  always_comb begin
    for (int d = 0; d < LANES; d++) begin
      vec[d] = (d < DIMS && count != '0) ? div_rsp.quo[d] : '0;
    end
  end

  msh_lap_store u_store (
    .clk       (clk),
    .pos_wr    (pos_wr),
    .pos_raddr (pos_raddr),
    .pos_rdata (pos_rdata),
    .nbr_wr    (nbr_wr),
    .nbr_raddr (nbr_raddr),
    .nbr_rdata (nbr_rdata)
  );

  msh_lap_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      nbr_limit     <= CFG_W'(LIMIT_RESET);
      e_valid       <= 1'b0;
      p_valid       <= 1'b0;
      stopped       <= 1'b0;
      vpos_live     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        nbr_limit <= cfg_data;
      end
      if (state == ST_RESULT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      vpos_live <= (state == ST_FETCH);
      unique case (state)
        ST_IDLE: begin
          if (in_fire && op == OP_COMPUTE) begin
            state   <= ST_FETCH;
            e_valid <= 1'b0;
            p_valid <= 1'b0;
            stopped <= 1'b0;
          end
        end
        ST_FETCH: begin
          e_valid <= 1'b1;
          state   <= ST_SCAN;
        end
        ST_SCAN: begin
          e_valid <= issue;
          p_valid <= take_entry;
          stopped <= stop_now;
          if (scan_done) begin
            state <= (count != '0) ? ST_DIVIDE : ST_RESULT;
          end
        end
        ST_DIVIDE: begin
          if (div_rsp.done) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers of the scan and the output stage.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire && op == OP_COMPUTE) begin
      vtx     <= s_axis_tdata[VTX_W-1:0];
      limit   <= limit_in;
      issue_k <= '0;
      count   <= '0;
      acc     <= '0;
    end
    if (state == ST_FETCH) begin
      issue_k <= CNT_W'(1);
    end
    if (state == ST_SCAN) begin
      if (vpos_live) begin
        vpos <= pos_rdata;
      end
      if (issue) begin
        issue_k <= issue_k + 1'b1;
      end
      if (take_entry) begin
        count <= count + 1'b1;
      end
      acc <= acc_next;
    end
    if (state == ST_RESULT && out_free) begin
      m_axis_tdata <= {count, vec[2], vec[1], vec[0]};
      m_axis_tuser <= (count == '0);
    end
  end

endmodule

`default_nettype wire

// ===== bench/mesh_umbrella_laplacian_top_tb.sv =====
// Self-checking bench for mesh_umbrella_laplacian_top: stream stimulus with random
// gaps and output stalls, and a scoreboard that predicts each umbrella mean.
// Depends on msh_lap_pkg and the block's RTL only.
`default_nettype none

module mesh_umbrella_laplacian_top_tb;
  import msh_lap_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Input tdata layout from bit 0, and the position of the output count field.
  localparam int SLOT_LSB = VTX_W;
  localparam int NBR_LSB  = SLOT_LSB + SLOT_W;
  localparam int PRES_BIT = NBR_LSB + VTX_W;
  localparam int POS_LSB  = PRES_BIT + 1;
  localparam int IN_FILL  = 104 - (POS_LSB + LANES * POS_W);
  localparam int CNT_LSB  = LANES * VEC_W;

  localparam int ITEM_TARGET  = 1150;
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [POS_W-1:0] COORD_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [POS_W-1:0] COORD_MAX = {1'b0, {(POS_W-1){1'b1}}};

  typedef logic [LANES-1:0][POS_W-1:0] xyz_t;

  typedef struct packed {
    logic [LANES-1:0][VEC_W-1:0] vec;
    logic [CNT_W-1:0]            count;
    logic                        skipped;
  } lap_result_t;

  class laplacian_scoreboard;
    xyz_t               coord_mem [VERTS];
    logic [ENTRY_W-1:0] slot_mem [VERTS*NEIGH_MAX];
    logic [CFG_W-1:0]   slots_cfg;
    lap_result_t        means_q [$];
    string              lane_name [LANES] = '{"vec_x", "vec_y", "vec_z"};
    int                 errors;
    int                 checked;
    int                 skipped_seen;

    function new();
      slots_cfg    = CFG_W'(LIMIT_RESET);
      errors       = 0;
      checked      = 0;
      skipped_seen = 0;
    endfunction

    function void set_slots(logic [CFG_W-1:0] value);
      slots_cfg = value;
    endfunction

    function int pending();
      return means_q.size();
    endfunction

    // Mean of (neighbor - vertex) over the leading present slots within the slot count, truncated toward zero.
    function lap_result_t umbrella_mean(logic [VTX_W-1:0] vtx);
      lap_result_t             r;
      logic [ENTRY_W-1:0]      e;
      logic signed [POS_W-1:0] own, other;
      longint                  sum [LANES];
      longint                  q;
      int                      lim, cnt, k, d;
      r = '0;
      if (!slot_mem[{vtx, SLOT_W'(0)}][VTX_W]) begin
        r.skipped = 1'b1;
        return r;
      end
      lim = (slots_cfg == 0) ? 1 : (slots_cfg > NEIGH_MAX) ? NEIGH_MAX : int'(slots_cfg);
      for (d = 0; d < LANES; d++) sum[d] = 0;
      cnt = 0;
      for (k = 0; k < lim; k++) begin
        e = slot_mem[{vtx, SLOT_W'(k)}];
        if (!e[VTX_W]) break;
        for (d = 0; d < LANES; d++) begin
          own    = coord_mem[vtx][d];
          other  = coord_mem[e[VTX_W-1:0]][d];
          sum[d] += other - own;
        end
        cnt++;
      end
      for (d = 0; d < LANES; d++) begin
        q = sum[d] / cnt;
        r.vec[d] = (d < DIMS) ? q[VEC_W-1:0] : '0;
      end
      r.count = CNT_W'(cnt);
      return r;
    endfunction

    function void note_item(logic [1:0] op, logic [103:0] data);
      logic [VTX_W-1:0] vtx;
      vtx = data[VTX_W-1:0];
      case (op)
        OP_LOAD_POS: coord_mem[vtx] = data[POS_LSB +: LANES*POS_W];
        OP_LOAD_NBR:
          slot_mem[{vtx, data[SLOT_LSB +: SLOT_W]}] = {data[PRES_BIT], data[NBR_LSB +: VTX_W]};
        OP_COMPUTE:  means_q.push_back(umbrella_mean(vtx));
        default: ;
      endcase
    endfunction

    function void check_result(logic [79:0] data, logic skipped);
      lap_result_t      want;
      logic [VEC_W-1:0] got;
      int               d;
      if (means_q.size() == 0) begin
        errors++;
        $error("result with no compute outstanding: tdata %h skipped %b", data, skipped);
        return;
      end
      want = means_q.pop_front();
      checked++;
      if (want.skipped) skipped_seen++;
      for (d = 0; d < LANES; d++) begin
        got = data[d*VEC_W +: VEC_W];
        if (got !== want.vec[d]) begin
          errors++;
          $error("%s: expected %0d, got %0d", lane_name[d], $signed(want.vec[d]),
                 $signed(got));
        end
      end
      if (data[CNT_LSB +: CNT_W] !== want.count) begin
        errors++;
        $error("neighbor_count: expected %0d, got %0d", want.count, data[CNT_LSB +: CNT_W]);
      end
      if (skipped !== want.skipped) begin
        errors++;
        $error("skipped: expected %0d, got %0d", want.skipped, skipped);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [103:0]       s_axis_tdata = '0;
  logic [1:0]         s_axis_tuser = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [79:0]        m_axis_tdata;
  logic [0:0]         m_axis_tuser;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;

  mesh_umbrella_laplacian_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
  );

  laplacian_scoreboard sb = new();

  // Stimulus-side view of what has been written, so that no compute ever
  // reads a position or a slot that was never loaded.
  bit                 pos_done [VERTS];
  bit                 slot_done [VERTS*NEIGH_MAX];
  logic [ENTRY_W-1:0] slot_shadow [VERTS*NEIGH_MAX];
  int                 pos_list [$];
  int                 built_q [$];
  int                 gen_slots = LIMIT_RESET;
  int                 items_sent = 0;
  int                 cfg_writes = 0;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  bit                 calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mesh_umbrella_laplacian_top test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tuser, s_axis_tdata);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [POS_W-1:0] pick_coord();
    case ($urandom_range(0, 11))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic xyz_t pick_xyz();
    xyz_t v;
    int   d;
    for (d = 0; d < LANES; d++) v[d] = pick_coord();
    return v;
  endfunction

  function automatic bit compute_safe(int vtx);
    logic [ENTRY_W-1:0] e;
    int                 lim, k, idx;
    idx = vtx * NEIGH_MAX;
    if (!slot_done[idx]) return 1'b0;
    if (!slot_shadow[idx][VTX_W]) return 1'b1;
    if (!pos_done[vtx]) return 1'b0;
    lim = (gen_slots == 0) ? 1 : (gen_slots > NEIGH_MAX) ? NEIGH_MAX : gen_slots;
    for (k = 0; k < lim; k++) begin
      if (!slot_done[idx + k]) return 1'b0;
      e = slot_shadow[idx + k];
      if (!e[VTX_W]) return 1'b1;
      if (!pos_done[e[VTX_W-1:0]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Leaves tvalid high after the accepting edge so the next item can follow
  // back to back; a gap lowers it first.
  task automatic send_item(input logic [1:0] op, input logic [VTX_W-1:0] vtx,
                           input logic [SLOT_W-1:0] slot, input logic [VTX_W-1:0] nbr,
                           input logic present, input xyz_t xyz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {IN_FILL'(0), xyz, present, nbr, slot, vtx};
    do @(posedge clk); while (!s_axis_tready);
    case (op)
      OP_LOAD_POS:
        if (!pos_done[vtx]) begin
          pos_done[vtx] = 1'b1;
          pos_list.push_back(vtx);
        end
      OP_LOAD_NBR: begin
        slot_done[{vtx, slot}]   = 1'b1;
        slot_shadow[{vtx, slot}] = {present, nbr};
      end
      default: ;
    endcase
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic load_pos(input int vtx, input xyz_t xyz);
    send_item(OP_LOAD_POS, VTX_W'(vtx), SLOT_W'($urandom()), VTX_W'($urandom()),
              1'($urandom()), xyz);
  endtask

  task automatic load_slot(input int vtx, input int slot, input int nbr, input bit present);
    send_item(OP_LOAD_NBR, VTX_W'(vtx), SLOT_W'(slot), VTX_W'(nbr), present, pick_xyz());
  endtask

  task automatic compute(input int vtx);
    send_item(OP_COMPUTE, VTX_W'(vtx), SLOT_W'($urandom()), VTX_W'($urandom()),
              1'($urandom()), pick_xyz());
  endtask

  // The slot count is only changed once the block has drained.
  task automatic set_slot_count(input int value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_slots(CFG_W'(value));
    gen_slots = value;
    cfg_writes++;
  endtask

  function automatic int pick_neighbor_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 50) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, NEIGH_MAX - 1);
    return NEIGH_MAX;
  endfunction

  // A complete vertex: its position, a list of loaded neighbors, an end marker
  // unless the list is full, maybe a stale slot past the marker, then a compute.
  task automatic build_vertex(input int vtx);
    int cnt, i, nbr;
    cnt = pick_neighbor_count();
    load_pos(vtx, pick_xyz());
    for (i = 0; i < cnt; i++) begin
      if (pos_list.size() > 0 && $urandom_range(0, 1))
        nbr = pos_list[$urandom_range(0, pos_list.size() - 1)];
      else
        nbr = $urandom_range(0, VERTS - 1);
      if (!pos_done[nbr]) load_pos(nbr, pick_xyz());
      load_slot(vtx, i, nbr, 1'b1);
    end
    if (cnt < NEIGH_MAX) begin
      load_slot(vtx, cnt, $urandom_range(0, VERTS - 1), 1'b0);
      if (cnt + 1 < NEIGH_MAX && $urandom_range(0, 3) == 0)
        load_slot(vtx, $urandom_range(cnt + 1, NEIGH_MAX - 1), $urandom_range(0, VERTS - 1),
                  1'($urandom()));
    end
    built_q.push_back(vtx);
    compute(vtx);
  endtask

  initial begin
    int   r, vtx, s, wait_cycles;
    xyz_t all_min, all_max;
    all_min = {LANES{COORD_MIN}};
    all_max = {LANES{COORD_MAX}};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Widest possible differences in both directions, a skipped vertex,
    // an ignored opcode and the slot-count extremes.
    load_pos(0, all_min);
    load_pos(VERTS - 1, all_max);
    for (s = 0; s < NEIGH_MAX; s++) load_slot(0, s, VERTS - 1, 1'b1);
    compute(0);
    load_slot(VERTS - 1, 0, 0, 1'b1);
    load_slot(VERTS - 1, 1, VERTS - 1, 1'b0);
    compute(VERTS - 1);
    load_slot(VERTS / 2, 0, $urandom_range(0, VERTS - 1), 1'b0);
    compute(VERTS / 2);
    send_item(OP_UNUSED, VTX_W'($urandom()), SLOT_W'($urandom()), VTX_W'($urandom()),
              1'($urandom()), pick_xyz());
    set_slot_count(0);
    compute(0);
    set_slot_count(31);
    compute(0);
    set_slot_count(LIMIT_RESET);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 39) == 0) calm = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 55 || built_q.size() == 0) begin
        build_vertex($urandom_range(0, VERTS - 1));
      end else if (r < 70) begin
        vtx = built_q[$urandom_range(0, built_q.size() - 1)];
        if (compute_safe(vtx)) compute(vtx);
      end else if (r < 78) begin
        vtx = $urandom_range(0, VERTS - 1);
        if (compute_safe(vtx)) compute(vtx);
      end else if (r < 86) begin
        load_pos(pos_list[$urandom_range(0, pos_list.size() - 1)], pick_xyz());
      end else if (r < 93) begin
        // Overwrite one slot; this may cut a list short or run it into
        // slots that later computes must then avoid.
        vtx = $urandom_range(0, 1) ? built_q[$urandom_range(0, built_q.size() - 1)]
                                   : $urandom_range(0, VERTS - 1);
        load_slot(vtx, $urandom_range(0, NEIGH_MAX - 1),
                  pos_list[$urandom_range(0, pos_list.size() - 1)], 1'($urandom()));
      end else if (r < 96) begin
        send_item(OP_UNUSED, VTX_W'($urandom()), SLOT_W'($urandom()), VTX_W'($urandom()),
                  1'($urandom()), pick_xyz());
      end else begin
        case ($urandom_range(0, 5))
          0:       set_slot_count(0);
          1:       set_slot_count(1);
          2:       set_slot_count(NEIGH_MAX);
          3:       set_slot_count(31);
          default: set_slot_count($urandom_range(0, 31));
        endcase
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    for (wait_cycles = 0; wait_cycles < 20000 && sb.pending() != 0; wait_cycles++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $error("%0d expected results never arrived", sb.pending());
    end

    $display("Sent %0d load and compute items over %0d slot-count settings.",
             items_sent, cfg_writes + 1);
    $display("Checked %0d Laplacian results, %0d of them skipped vertices.",
             sb.checked, sb.skipped_seen);
    if (sb.errors == 0)
      $display("mesh_umbrella_laplacian_top test passed");
    else
      $display("mesh_umbrella_laplacian_top test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== mesh_umbrella_laplacian_top.f =====
src/msh_lap_pkg.sv
src/msh_lap_store.sv
src/msh_lap_div.sv
src/mesh_umbrella_laplacian_top.sv
bench/mesh_umbrella_laplacian_top_tb.sv
